// File: src/rqal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rqal_pkg;

    localparam int IDW = 32;
    localparam int PLW = 16;
    localparam int ATW = 4;
    localparam int TW  = 32;
    localparam int TOW = 16;
    localparam int EVW = 3;
    localparam int OCW = 5;

    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_ACK    = 2'd1;
    localparam logic [1:0] OP_SWEEP  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [EVW-1:0] EV_SENT    = 3'd0;
    localparam logic [EVW-1:0] EV_QUEUED  = 3'd1;
    localparam logic [EVW-1:0] EV_FULL    = 3'd2;
    localparam logic [EVW-1:0] EV_DROPPED = 3'd3;
    localparam logic [EVW-1:0] EV_ACKED   = 3'd4;
    localparam logic [EVW-1:0] EV_UNKNOWN = 3'd5;
    localparam logic [EVW-1:0] EV_DONE    = 3'd6;

    localparam logic CFG_ATTEMPT_LIMIT = 1'b0;
    localparam logic CFG_TIMEOUT       = 1'b1;

    localparam logic [ATW-1:0] ATTEMPT_MAX   = 4'd15;
    localparam logic [ATW-1:0] LIMIT_RESET   = 4'd5;
    localparam logic [TOW-1:0] TIMEOUT_RESET = 16'd1000;

    typedef struct packed {
        logic [IDW-1:0] id;
        logic [PLW-1:0] payload;
        logic [ATW-1:0] attempts;
        logic           sent;
        logic [TW-1:0]  sent_time;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUBMIT,
        ST_SCAN,
        ST_FINAL
    } state_t;

endpackage

`default_nettype wire

// File: src/rqal_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module rqal_ring #(
    parameter int DEPTH = 16
) (
    input  wire                       aclk,
    input  wire                       wr_en,
    input  wire [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire rqal_pkg::entry_t     wr_data,
    input  wire                       rd_en,
    input  wire [$clog2(DEPTH)-1:0]   rd_addr,
    output rqal_pkg::entry_t          rd_data
);

    rqal_pkg::entry_t mem [DEPTH];
    rqal_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: src/retry_queue_with_attempt_limit_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Submit: the input beat is registered, the entry is written in the submit state
// and the result beat is registered; the next input beat is taken back in the idle
// state. Acknowledge and sweep: an empty table or a sweep with the link down goes
// straight to the final beat and a found acknowledge ends on its acked beat; the
// table is one ring memory and the scan pops and pushes back one entry per cycle.
// A stalled result beat halts the scan; s_tready is high only between items.
// Reset (aresetn low, synchronous) empties the table, zeroes the id counter and
// restores the register defaults; table memory contents are not cleared.
module retry_queue_with_attempt_limit_core #(
    parameter int DEPTH = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire         cfg_index,
    input  wire [15:0]  cfg_wdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    // payload_handle[15:0], ack_id[47:16], now_ticks[79:48], link_up[80], zeros
    input  wire [87:0]  s_tdata,
    // opcode[1:0]
    input  wire [1:0]   s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // entry_id[31:0], entry_payload[47:32], attempt_count[51:48],
    // occupancy[56:52], zeros
    output logic [63:0] m_tdata,
    // event_kind[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rqal_pkg::state_t state_reg, state_next;

    logic [AW-1:0] head_reg, tail_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] rd_left_reg, proc_left_reg;
    logic          rd_valid_reg;
    logic          found_reg;
    logic [31:0]   next_id_reg;

    logic [3:0]    limit_reg;
    logic [15:0]   timeout_reg;

    logic [1:0]    op_reg;
    logic [15:0]   in_payload_reg;
    logic [31:0]   ack_reg;
    logic [31:0]   now_reg;
    logic          link_reg;

    logic          out_valid_reg;
    logic [2:0]    out_kind_reg;
    logic [31:0]   out_id_reg;
    logic [15:0]   out_payload_reg;
    logic [3:0]    out_attempts_reg;
    logic [4:0]    out_occ_reg;
    logic          out_last_reg;

    rqal_pkg::entry_t rd_entry;
    rqal_pkg::entry_t wr_entry;
    logic [AW-1:0]    wr_addr;
    logic             wr_en;
    logic             rd_en;

    logic          in_fire;
    logic          out_free;
    logic          emit;
    logic [2:0]    ev_kind;
    logic [31:0]   ev_id;
    logic [15:0]   ev_payload;
    logic [3:0]    ev_attempts;
    logic [CW-1:0] ev_count;
    logic          ev_last;
    logic          proc_fire;
    logic          scan_done;
    logic          found_now;
    logic          submit_ok;
    logic          count_dec;
    logic          due;
    logic          drop;
    logic          match;
    logic [31:0]   elapsed;
    logic [3:0]    attempts_inc;
    logic [AW-1:0] head_inc, tail_inc;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign tail_inc = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);

    // Per-entry decisions for the entry held in the read register.
    assign elapsed      = now_reg - rd_entry.sent_time;
    assign due          = !rd_entry.sent || (elapsed >= {16'd0, timeout_reg});
    assign drop         = due && (rd_entry.attempts >= limit_reg);
    assign match        = !found_reg && (rd_entry.id == ack_reg);
    assign attempts_inc = (rd_entry.attempts == rqal_pkg::ATTEMPT_MAX) ?
                          rd_entry.attempts : rd_entry.attempts + 4'd1;

    rqal_ring #(
        .DEPTH(DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_entry)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rqal_pkg::ST_IDLE: begin
                if (in_fire) begin
                    unique case (s_tuser)
                        rqal_pkg::OP_SUBMIT: state_next = rqal_pkg::ST_SUBMIT;
                        rqal_pkg::OP_ACK: begin
                            state_next = (count_reg == '0) ? rqal_pkg::ST_FINAL
                                                           : rqal_pkg::ST_SCAN;
                        end
                        rqal_pkg::OP_SWEEP: begin
                            state_next = (s_tdata[80] && count_reg != '0) ?
                                         rqal_pkg::ST_SCAN : rqal_pkg::ST_FINAL;
                        end
                        rqal_pkg::OP_NONE: state_next = rqal_pkg::ST_IDLE;
                    endcase
                end
            end
            rqal_pkg::ST_SUBMIT: begin
                if (out_free) begin
                    state_next = rqal_pkg::ST_IDLE;
                end
            end
            rqal_pkg::ST_SCAN: begin
                if (scan_done) begin
                    if (op_reg == rqal_pkg::OP_ACK && (found_reg || found_now)) begin
                        state_next = rqal_pkg::ST_IDLE;
                    end else begin
                        state_next = rqal_pkg::ST_FINAL;
                    end
                end
            end
            rqal_pkg::ST_FINAL: begin
                if (out_free) begin
                    state_next = rqal_pkg::ST_IDLE;
                end
            end
            default: state_next = rqal_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        emit        = 1'b0;
        ev_kind     = rqal_pkg::EV_DONE;
        ev_id       = '0;
        ev_payload  = '0;
        ev_attempts = '0;
        ev_count    = count_reg;
        ev_last     = 1'b0;
        proc_fire   = 1'b0;
        scan_done   = 1'b0;
        found_now   = 1'b0;
        submit_ok   = 1'b0;
        count_dec   = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = tail_reg;
        wr_entry    = rd_entry;
        unique case (state_reg)
            rqal_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            rqal_pkg::ST_SUBMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    ev_last = 1'b1;
                    if (count_reg == CW'(DEPTH)) begin
                        ev_kind = rqal_pkg::EV_FULL;
                    end else begin
                        submit_ok          = 1'b1;
                        wr_en              = 1'b1;
                        wr_entry.id        = next_id_reg;
                        wr_entry.payload   = in_payload_reg;
                        wr_entry.attempts  = link_reg ? 4'd1 : 4'd0;
                        wr_entry.sent      = link_reg;
                        wr_entry.sent_time = link_reg ? now_reg : 32'd0;
                        ev_kind     = link_reg ? rqal_pkg::EV_SENT : rqal_pkg::EV_QUEUED;
                        ev_id       = next_id_reg;
                        ev_payload  = in_payload_reg;
                        ev_attempts = link_reg ? 4'd1 : 4'd0;
                        ev_count    = count_reg + CW'(1);
                    end
                end
            end
            rqal_pkg::ST_SCAN: begin
                if (rd_valid_reg) begin
                    if (op_reg == rqal_pkg::OP_ACK) begin
                        if (match) begin
                            proc_fire   = out_free;
                            emit        = out_free;
                            found_now   = out_free;
                            count_dec   = out_free;
                            ev_kind     = rqal_pkg::EV_ACKED;
                            ev_id       = ack_reg;
                            ev_payload  = rd_entry.payload;
                            ev_attempts = rd_entry.attempts;
                            ev_count    = count_reg - CW'(1);
                            ev_last     = 1'b1;
                        end else begin
                            proc_fire = 1'b1;
                            wr_en     = 1'b1;
                        end
                    end else begin
                        if (!due) begin
                            // Still in flight: goes back to the tail untouched.
                            proc_fire = 1'b1;
                            wr_en     = 1'b1;
                        end else if (drop) begin
                            proc_fire   = out_free;
                            emit        = out_free;
                            count_dec   = out_free;
                            ev_kind     = rqal_pkg::EV_DROPPED;
                            ev_id       = rd_entry.id;
                            ev_payload  = rd_entry.payload;
                            ev_attempts = rd_entry.attempts;
                            ev_count    = count_reg - CW'(1);
                        end else begin
                            proc_fire          = out_free;
                            emit               = out_free;
                            wr_en              = out_free;
                            wr_entry.attempts  = attempts_inc;
                            wr_entry.sent      = 1'b1;
                            wr_entry.sent_time = now_reg;
                            ev_kind     = rqal_pkg::EV_SENT;
                            ev_id       = rd_entry.id;
                            ev_payload  = rd_entry.payload;
                            ev_attempts = attempts_inc;
                        end
                    end
                end
                scan_done = proc_fire && (proc_left_reg == CW'(1));
                rd_en     = (rd_left_reg != '0) && (!rd_valid_reg || proc_fire);
            end
            rqal_pkg::ST_FINAL: begin
                if (out_free) begin
                    emit    = 1'b1;
                    ev_last = 1'b1;
                    if (op_reg == rqal_pkg::OP_ACK) begin
                        ev_kind = rqal_pkg::EV_UNKNOWN;
                        ev_id   = ack_reg;
                    end else begin
                        ev_kind = rqal_pkg::EV_DONE;
                    end
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rqal_pkg::ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rd_left_reg   <= '0;
            proc_left_reg <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            next_id_reg   <= '0;
            limit_reg     <= rqal_pkg::LIMIT_RESET;
            timeout_reg   <= rqal_pkg::TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                if (cfg_index == rqal_pkg::CFG_ATTEMPT_LIMIT) begin
                    limit_reg <= cfg_wdata[3:0];
                end else begin
                    timeout_reg <= cfg_wdata;
                end
            end

            if (in_fire) begin
                rd_left_reg   <= count_reg;
                proc_left_reg <= count_reg;
                found_reg     <= 1'b0;
                rd_valid_reg  <= 1'b0;
            end else begin
                if (rd_en) begin
                    rd_left_reg <= rd_left_reg - CW'(1);
                end
                if (proc_fire) begin
                    proc_left_reg <= proc_left_reg - CW'(1);
                end
                if (found_now) begin
                    found_reg <= 1'b1;
                end
                if (rd_en) begin
                    rd_valid_reg <= 1'b1;
                end else if (proc_fire) begin
                    rd_valid_reg <= 1'b0;
                end
            end

            // The head pops on every read and the tail pushes on every write.
            if (rd_en) begin
                head_reg <= head_inc;
            end
            if (wr_en) begin
                tail_reg <= tail_inc;
            end

            if (submit_ok) begin
                count_reg   <= count_reg + CW'(1);
                next_id_reg <= next_id_reg + 32'd1;
            end else if (count_dec) begin
                count_reg <= count_reg - CW'(1);
            end

            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg         <= s_tuser;
            in_payload_reg <= s_tdata[15:0];
            ack_reg        <= s_tdata[47:16];
            now_reg        <= s_tdata[79:48];
            link_reg       <= s_tdata[80];
        end
        if (emit) begin
            out_kind_reg     <= ev_kind;
            out_id_reg       <= ev_id;
            out_payload_reg  <= ev_payload;
            out_attempts_reg <= ev_attempts;
            out_occ_reg      <= 5'(ev_count);
            out_last_reg     <= ev_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_occ_reg, out_attempts_reg, out_payload_reg, out_id_reg};

endmodule

`default_nettype wire

// File: bench/retry_queue_with_attempt_limit_core_test.sv
`timescale 1ns / 1ps

module retry_queue_with_attempt_limit_core_test;

    localparam int DEPTH      = 16;
    localparam int QUIET_MAX  = 20000;
    localparam int SETTLE     = 40;

    typedef struct packed {
        logic [rqal_pkg::EVW-1:0] kind;
        logic [rqal_pkg::IDW-1:0] id;
        logic [rqal_pkg::PLW-1:0] payload;
        logic [rqal_pkg::ATW-1:0] attempts;
        logic [rqal_pkg::OCW-1:0] occupancy;
        logic                     last;
    } report_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Shadow of the retransmission table and its registers.
    logic [rqal_pkg::IDW-1:0] tbl_id       [DEPTH];
    logic [rqal_pkg::PLW-1:0] tbl_payload  [DEPTH];
    logic [rqal_pkg::ATW-1:0] tbl_attempts [DEPTH];
    logic                     tbl_sent     [DEPTH];
    logic [rqal_pkg::TW-1:0]  tbl_stamp    [DEPTH];
    int unsigned              tbl_count = 0;
    logic [rqal_pkg::IDW-1:0] id_next = '0;
    logic [rqal_pkg::ATW-1:0] limit_reg = rqal_pkg::LIMIT_RESET;
    logic [rqal_pkg::TOW-1:0] timeout_reg = rqal_pkg::TIMEOUT_RESET;

    report_t     pending_events[$];
    int unsigned mismatches = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    logic [rqal_pkg::TW-1:0] tick_now = 32'hFFFF_0000;

    retry_queue_with_attempt_limit_core #(
        .DEPTH(DEPTH)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic report_t make_report(logic [rqal_pkg::EVW-1:0] kind,
                                            logic [rqal_pkg::IDW-1:0] id,
                                            logic [rqal_pkg::PLW-1:0] payload,
                                            logic [rqal_pkg::ATW-1:0] att);
        report_t r;
        r.kind      = kind;
        r.id        = id;
        r.payload   = payload;
        r.attempts  = att;
        r.occupancy = rqal_pkg::OCW'(tbl_count);
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic void mark_sent(int unsigned i, logic [rqal_pkg::TW-1:0] now);
        if (tbl_attempts[i] < rqal_pkg::ATTEMPT_MAX)
            tbl_attempts[i] = tbl_attempts[i] + 4'd1;
        tbl_sent[i]  = 1'b1;
        tbl_stamp[i] = now;
    endfunction

    function automatic void remove_entry(int unsigned i);
        for (int unsigned j = i; j + 1 < tbl_count; j++) begin
            tbl_id[j]       = tbl_id[j + 1];
            tbl_payload[j]  = tbl_payload[j + 1];
            tbl_attempts[j] = tbl_attempts[j + 1];
            tbl_sent[j]     = tbl_sent[j + 1];
            tbl_stamp[j]    = tbl_stamp[j + 1];
        end
        tbl_count--;
    endfunction

    // Applies one accepted command to the shadow table and queues the events it causes.
    task automatic predict_events(input logic [1:0] op,
                                  input logic [rqal_pkg::PLW-1:0] payload,
                                  input logic [rqal_pkg::IDW-1:0] ack,
                                  input logic [rqal_pkg::TW-1:0] now,
                                  input logic link);
        report_t                  batch[$];
        int unsigned              i;
        logic                     found;
        logic [rqal_pkg::TW-1:0]  elapsed;
        logic [rqal_pkg::IDW-1:0] gone_id;
        logic [rqal_pkg::PLW-1:0] gone_payload;
        logic [rqal_pkg::ATW-1:0] gone_attempts;
        case (op)
            rqal_pkg::OP_SUBMIT: begin
                if (tbl_count >= DEPTH) begin
                    batch = {batch, make_report(rqal_pkg::EV_FULL, '0, '0, '0)};
                end else begin
                    i = tbl_count;
                    tbl_id[i]       = id_next;
                    tbl_payload[i]  = payload;
                    tbl_attempts[i] = '0;
                    tbl_sent[i]     = 1'b0;
                    tbl_stamp[i]    = '0;
                    id_next         = id_next + 32'd1;
                    tbl_count++;
                    if (link) begin
                        mark_sent(i, now);
                        batch = {batch, make_report(rqal_pkg::EV_SENT, tbl_id[i], payload,
                                                    tbl_attempts[i])};
                    end else begin
                        batch = {batch, make_report(rqal_pkg::EV_QUEUED, tbl_id[i], payload,
                                                    '0)};
                    end
                end
            end
            rqal_pkg::OP_ACK: begin
                found = 1'b0;
                for (i = 0; i < tbl_count; i++) begin
                    if (!found && tbl_id[i] == ack) begin
                        found         = 1'b1;
                        gone_payload  = tbl_payload[i];
                        gone_attempts = tbl_attempts[i];
                        remove_entry(i);
                        batch = {batch, make_report(rqal_pkg::EV_ACKED, ack, gone_payload,
                                                    gone_attempts)};
                    end
                end
                if (!found)
                    batch = {batch, make_report(rqal_pkg::EV_UNKNOWN, ack, '0, '0)};
            end
            rqal_pkg::OP_SWEEP: begin
                i = 0;
                while (link && i < tbl_count) begin
                    elapsed = now - tbl_stamp[i];
                    if (tbl_sent[i] && elapsed < {16'd0, timeout_reg}) begin
                        i++;
                    end else if (tbl_attempts[i] >= limit_reg) begin
                        gone_id       = tbl_id[i];
                        gone_payload  = tbl_payload[i];
                        gone_attempts = tbl_attempts[i];
                        remove_entry(i);
                        batch = {batch, make_report(rqal_pkg::EV_DROPPED, gone_id,
                                                    gone_payload, gone_attempts)};
                    end else begin
                        mark_sent(i, now);
                        batch = {batch, make_report(rqal_pkg::EV_SENT, tbl_id[i],
                                                    tbl_payload[i], tbl_attempts[i])};
                        i++;
                    end
                end
                batch = {batch, make_report(rqal_pkg::EV_DONE, '0, '0, '0)};
            end
            default: ;
        endcase
        if (batch.size() > 0) begin
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[k])
                pending_events = {pending_events, batch[k]};
        end
    endtask

    task automatic send_item(input logic [1:0] op, input logic [rqal_pkg::PLW-1:0] payload,
                             input logic [rqal_pkg::IDW-1:0] ack,
                             input logic [rqal_pkg::TW-1:0] now,
                             input logic link);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, link, now, ack, payload};
        do @(posedge aclk); while (!s_tready);
        predict_events(op, payload, ack, now, link);
    endtask

    task automatic send_random_item();
        int unsigned              pick;
        logic [1:0]               op;
        logic [rqal_pkg::IDW-1:0] ack;
        pick = $urandom_range(99);
        if (pick < 35)
            op = rqal_pkg::OP_SUBMIT;
        else if (pick < 65)
            op = rqal_pkg::OP_ACK;
        else if (pick < 95)
            op = rqal_pkg::OP_SWEEP;
        else
            op = rqal_pkg::OP_NONE;
        if ($urandom_range(19) == 0)
            tick_now = $urandom();
        else
            tick_now = tick_now + $urandom_range(2 * timeout_reg + 2);
        if (op == rqal_pkg::OP_ACK && tbl_count > 0 && $urandom_range(4) != 0)
            ack = tbl_id[$urandom_range(tbl_count - 1)];
        else if ($urandom_range(1) == 1)
            ack = id_next - $urandom_range(1, 40);
        else
            ack = $urandom();
        send_item(op, rqal_pkg::PLW'($urandom()), ack, tick_now, $urandom_range(99) < 85);
    endtask

    task automatic wait_until_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_events.size() > 0)
            @(posedge aclk);
        // Let a trailing command that produces no result finish too.
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [15:0] value);
        wait_until_drained();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == rqal_pkg::CFG_ATTEMPT_LIMIT)
            limit_reg = value[rqal_pkg::ATW-1:0];
        else
            timeout_reg = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_basic_operations();
        send_item(rqal_pkg::OP_SWEEP, 16'h1234, 32'h0, 32'h0, 1'b1);
        send_item(rqal_pkg::OP_NONE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(rqal_pkg::OP_ACK, 16'h0, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_item(rqal_pkg::OP_SUBMIT, 16'h0000, 32'h0, 32'h0, 1'b0);
        send_item(rqal_pkg::OP_SUBMIT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b1);
        send_item(rqal_pkg::OP_SWEEP, 16'h0, 32'h0, 32'h8000_0000, 1'b0);
        send_item(rqal_pkg::OP_ACK, 16'hAAAA, 32'h0, 32'h0, 1'b1);
        // One tick short of the timeout, then exactly on it, across the wrap of time.
        send_item(rqal_pkg::OP_SWEEP, 16'h0, 32'h0, 32'h0000_03D7, 1'b1);
        send_item(rqal_pkg::OP_SWEEP, 16'h0, 32'h0, 32'h0000_03D8, 1'b1);
    endtask

    task automatic test_full_table();
        for (int k = 0; k < DEPTH - 1; k++)
            send_item(rqal_pkg::OP_SUBMIT, rqal_pkg::PLW'($urandom()), $urandom(),
                      $urandom(), 1'b0);
        send_item(rqal_pkg::OP_SUBMIT, 16'h5555, 32'h0, 32'h0000_0400, 1'b1);
        send_item(rqal_pkg::OP_SWEEP, 16'h0, 32'h0, 32'h0000_0400, 1'b1);
    endtask

    task automatic test_limit_extremes();
        write_register(rqal_pkg::CFG_ATTEMPT_LIMIT, {12'hABC, 4'd0});
        write_register(rqal_pkg::CFG_TIMEOUT, 16'd0);
        send_item(rqal_pkg::OP_SWEEP, 16'h0, 32'h0, 32'h0000_0401, 1'b1);
        write_register(rqal_pkg::CFG_ATTEMPT_LIMIT, {12'h543, 4'd15});
        send_item(rqal_pkg::OP_SUBMIT, 16'h0F0F, 32'h0, 32'h0, 1'b0);
        send_item(rqal_pkg::OP_SUBMIT, 16'hF0F0, 32'h0, 32'h0, 1'b0);
        // Fifteen sends bring both entries to the top count; the next sweep drops them.
        for (int k = 0; k <= 15; k++)
            send_item(rqal_pkg::OP_SWEEP, 16'h0, 32'h0, 32'(k), 1'b1);
    endtask

    task automatic test_receiver_hold();
        write_register(rqal_pkg::CFG_ATTEMPT_LIMIT, 16'd4);
        write_register(rqal_pkg::CFG_TIMEOUT, 16'd50);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 400;
        repeat (40) send_random_item();
    endtask

    task automatic test_random_traffic(input int unsigned count, input int unsigned send_pct,
                                       input int unsigned recv_pct, input logic [3:0] limit,
                                       input logic [15:0] timeout);
        write_register(rqal_pkg::CFG_ATTEMPT_LIMIT, {12'($urandom()), limit});
        write_register(rqal_pkg::CFG_TIMEOUT, timeout);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_random_item();
    endtask

    // Receiver side: random stalls, plus a long counted hold-off when requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $error("result beat with nothing expected: kind %0d id %0h", m_tuser,
                       m_tdata[31:0]);
                mismatches++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", want.kind, m_tuser);
                check_field("entry_id", want.id, m_tdata[31:0]);
                check_field("entry_payload", want.payload, m_tdata[47:32]);
                check_field("attempt_count", want.attempts, m_tdata[51:48]);
                check_field("occupancy", want.occupancy, m_tdata[56:52]);
                check_field("last_of_run", want.last, m_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("retry_queue_with_attempt_limit_core_test failed");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_basic_operations();
        test_full_table();
        test_limit_extremes();
        test_receiver_hold();
        test_random_traffic(65, 0, 0, 4'd5, 16'd1000);
        test_random_traffic(65, 65, 0, 4'd1, 16'd1);
        test_random_traffic(65, 0, 65, 4'd15, 16'hFFFF);
        test_random_traffic(65, 6, 6, 4'd3, 16'd300);

        wait_until_drained();
        if (mismatches == 0)
            $display("retry_queue_with_attempt_limit_core_test passed");
        else
            $display("retry_queue_with_attempt_limit_core_test failed");
        $finish;
    end

endmodule

// File: filelist.f
src/rqal_pkg.sv
src/rqal_ring.sv
src/retry_queue_with_attempt_limit_core.sv
bench/retry_queue_with_attempt_limit_core_test.sv
